FILE: rtl/core/pfd_pkg.sv
// Shared constants, codes and types for the PDM FIR decimator.
package pfd_pkg;

  localparam int TAPS          = 256;
  localparam int LANES         = 4;
  localparam int DEPTH         = TAPS / LANES;
  localparam int DEPTH_W       = $clog2(DEPTH);
  localparam int LANE_W        = $clog2(LANES);
  localparam int WORD_BITS     = 16;
  localparam int DECIMATION    = 64;
  localparam int WORDS_PER_OUT = DECIMATION / WORD_BITS;
  localparam int PHASE_W       = $clog2(WORDS_PER_OUT);
  localparam int IDX_W         = 8;
  localparam int COEF_W        = 16;
  localparam int ACC_W         = COEF_W + DEPTH_W;
  localparam int SUM_W         = ACC_W + LANE_W;
  localparam int PCM_W         = 40;
  localparam int ONE_SHIFT     = 16;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_LOAD = 1'b1
  } opcode_t;

  typedef struct packed {
    logic               clear;
    logic               rd_en;
    logic [DEPTH_W-1:0] rd_addr;
  } lane_ctrl_t;

  typedef logic signed [ACC_W-1:0] lane_acc_t;

endpackage

FILE: rtl/core/pfd_lane.sv
// One filter lane: a coefficient bank and a masked accumulator over its taps.
module pfd_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic        [pfd_pkg::DEPTH_W-1:0] wr_addr,
  input  logic signed [pfd_pkg::COEF_W-1:0]  wr_data,
  input  pfd_pkg::lane_ctrl_t               ctrl,
  input  logic                              tap,
  output pfd_pkg::lane_acc_t                acc
);

  logic signed [pfd_pkg::COEF_W-1:0] mem [pfd_pkg::DEPTH];
  logic signed [pfd_pkg::COEF_W-1:0] rdata_r;
  logic                              tap_r;
  logic                              vld_r;
  pfd_pkg::lane_acc_t                acc_r;
  pfd_pkg::lane_acc_t                acc_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rdata_r <= mem[ctrl.rd_addr];
    end
    tap_r <= tap;
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctrl.rd_en;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (vld_r && tap_r) begin
      acc_nxt = acc_r + pfd_pkg::ACC_W'(rdata_r);
    end
  end

  assign acc = acc_r;

endmodule

FILE: rtl/core/pfd_merge.sv
// Merge stage: adds the lane sums and scales by the one-level sample value.
module pfd_merge (
  input  logic                                      clk,
  input  logic                                      load,
  input  pfd_pkg::lane_acc_t [pfd_pkg::LANES-1:0]   accs,
  output logic signed [pfd_pkg::PCM_W-1:0]          pcm
);

  logic signed [pfd_pkg::SUM_W-1:0] sum_nxt;
  logic signed [pfd_pkg::SUM_W-1:0] sum_r;
  logic signed [pfd_pkg::PCM_W-1:0] wide;

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < pfd_pkg::LANES; k++) begin
      sum_nxt = sum_nxt + pfd_pkg::SUM_W'($signed(accs[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_r <= sum_nxt;
    end
  end

  assign wide = pfd_pkg::PCM_W'(sum_r);
  assign pcm  = (wide <<< pfd_pkg::ONE_SHIFT) - wide;

endmodule

FILE: rtl/core/pdm_fir_decimator_core.sv
// Top level: PDM word unpacking, bit history, lane control and PCM output register.
// Window sum: a push that completes a decimation window raises out_valid once the
//   bank reads of all lanes in S_SUM, then S_DRAIN, S_MERGE and S_OUT have passed.
// Input: other pushes and coefficient loads are taken whenever in_stall is low; in_stall
//   is high from the window sum until S_OUT writes the output, which waits on out_stall.
// Reset clears the bit history, word phase, sequencer and output valid.
module pdm_fir_decimator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_opcode,
  input  logic        [15:0]                  in_pdm_word,
  input  logic        [pfd_pkg::IDX_W-1:0]    in_coef_index,
  input  logic signed [pfd_pkg::COEF_W-1:0]   in_coef_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pfd_pkg::PCM_W-1:0]    out_pcm_sample
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DRAIN,
    S_MERGE,
    S_OUT
  } state_t;

  state_t                              state_r;
  logic [pfd_pkg::DEPTH_W-1:0]         cnt_r;
  logic [pfd_pkg::PHASE_W-1:0]         phase_r;
  logic [pfd_pkg::TAPS-1:0]            hist_r;
  logic [pfd_pkg::WORD_BITS-1:0]       word_rev;
  logic                                out_valid_r;
  logic signed [pfd_pkg::PCM_W-1:0]    out_pcm_r;
  logic                                accept;
  logic                                push;
  logic                                load;
  logic                                idx_ok;
  logic                                out_free;
  pfd_pkg::lane_ctrl_t                 ctrl;
  pfd_pkg::lane_acc_t [pfd_pkg::LANES-1:0] accs;
  logic signed [pfd_pkg::PCM_W-1:0]    pcm;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign push     = accept && (pfd_pkg::opcode_t'(in_opcode) == pfd_pkg::OP_PUSH);
  assign load     = accept && (pfd_pkg::opcode_t'(in_opcode) == pfd_pkg::OP_LOAD);
  assign idx_ok   = ({1'b0, in_coef_index} < (pfd_pkg::IDX_W + 1)'(pfd_pkg::TAPS));
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    for (int b = 0; b < pfd_pkg::WORD_BITS; b++) begin
      word_rev[b] = in_pdm_word[pfd_pkg::WORD_BITS-1-b];
    end
  end

  always_comb begin
    ctrl.clear   = (state_r == S_IDLE);
    ctrl.rd_en   = (state_r == S_SUM);
    ctrl.rd_addr = cnt_r;
  end

  for (genvar k = 0; k < pfd_pkg::LANES; k++) begin : g_lane
    logic [pfd_pkg::DEPTH-1:0] lane_hist;
    logic                      wr_en;

    assign lane_hist = hist_r[k*pfd_pkg::DEPTH +: pfd_pkg::DEPTH];
    assign wr_en     = load && idx_ok &&
                       (in_coef_index[pfd_pkg::DEPTH_W +: pfd_pkg::LANE_W] ==
                        pfd_pkg::LANE_W'(k));

    pfd_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (wr_en),
      .wr_addr (in_coef_index[pfd_pkg::DEPTH_W-1:0]),
      .wr_data (in_coef_value),
      .ctrl    (ctrl),
      .tap     (lane_hist[cnt_r]),
      .acc     (accs[k])
    );
  end

  pfd_merge u_merge (
    .clk  (clk),
    .load (state_r == S_MERGE),
    .accs (accs),
    .pcm  (pcm)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      phase_r     <= '0;
      hist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (push) begin
            hist_r  <= {word_rev, hist_r[pfd_pkg::TAPS-1:pfd_pkg::WORD_BITS]};
            phase_r <= phase_r + 1'b1;
            if (phase_r == pfd_pkg::PHASE_W'(pfd_pkg::WORDS_PER_OUT - 1)) begin
              state_r <= S_SUM;
            end
          end
        end
        S_SUM: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == pfd_pkg::DEPTH_W'(pfd_pkg::DEPTH - 1)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_MERGE;
        end
        S_MERGE: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_pcm_r <= pcm;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pcm_sample = out_pcm_r;

endmodule
